// ----- design/ddo_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, register indexes, reset values and the arctangent table of the
// differential-drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 26;

  localparam logic [CfgIdxW-1:0] CfgMmPerTick  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAnglePerMm = 2'd1;

  localparam logic [23:0] MmPerTickReset  = 24'd422070;
  localparam logic [25:0] AnglePerMmReset = 26'd13145487;

  // cordic start vector, q1.30
  localparam logic signed [33:0] CordicKinv = 34'sd652032874;

  // sequencer states
  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StMulL   = 9'b000000010,
    StMulR   = 9'b000000100,
    StTurn   = 9'b000001000,
    StPrep   = 9'b000010000,
    StCordic = 9'b000100000,
    StMulX   = 9'b001000000,
    StMulY   = 9'b010000000,
    StOut    = 9'b100000000
  } state_e;

  // arctangent of 2^-i as a binary angle, rounded to nearest
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      5'd28:   v = 32'd3;
      5'd29:   v = 32'd1;
      5'd30:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // clamp a 49-bit sum to the signed 48-bit range
  function automatic logic [47:0] sat48(input logic [48:0] v);
    logic [47:0] r;
    if (v[48] == v[47]) begin
      r = v[47:0];
    end else if (v[48]) begin
      r = {1'b1, 47'd0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/ddo_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_if
// Valid/ready channels of the odometry block: wheel tick items in, pose
// items out.
// ----------------------------------------------------------------------------
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_ticks;
  logic signed [15:0] right_ticks;

  modport source (output valid, output left_ticks, output right_ticks, input ready);
  modport sink   (input valid, input left_ticks, input right_ticks, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] x_out;
  logic signed [47:0] y_out;
  logic        [31:0] heading_out;

  modport source (output valid, output x_out, output y_out, output heading_out,
                  input ready);
  modport sink   (input valid, input x_out, input y_out, input heading_out,
                  output ready);
endinterface
`default_nettype wire

// ----- design/diff_drive_odometry.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Dead-reckoning pose tracker for a two-wheel robot, midpoint heading rule.
//
// in_i carries signed left/right encoder tick deltas; out_o returns the new
// X and Y (signed Q32.16 mm, saturating) and heading (2^32 = one turn).
// cfg_we_i/cfg_idx_i/cfg_data_i write mm_per_tick (index 0) and
// angle_per_mm (index 1); other indexes are ignored.
// One item at a time: after accept, in_i.ready stays low while a single
// shared 34x17 multiplier and one shift-add cordic datapath are sequenced:
// left and right wheel scaling, the turn product, the angle setup, the
// cordic iterations, then the X and Y products.
// The result is loaded into the output register as the sequencer returns
// to idle, and in_i.ready rises with it.
// A new item may be taken while the previous result still waits; if the
// receiver stalls, the next result waits in its last state until the output
// register frees up.
// Reset clears pose and heading to zero and loads the default registers.
// ----------------------------------------------------------------------------
module diff_drive_odometry #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [ddo_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire  [ddo_pkg::CfgDataW-1:0]      cfg_data_i,
  ddo_in_if.sink                            in_i,
  ddo_out_if.source                         out_o
);

  localparam logic [4:0] LastStep = 5'(CORDIC_STEPS - 1);

  ddo_pkg::state_e state_q, state_d;

  logic [23:0] mpt_q;
  logic [25:0] apm_q;

  logic signed [15:0] lt_q, rt_q;
  logic signed [39:0] dl_q, ds_q;
  logic signed [40:0] diff_q;
  logic        [31:0] turn_q, half_q;
  logic signed [71:0] acc_q, acc_d;
  logic        [1:0]  dig_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic               flip_q;
  logic        [4:0]  step_q;

  logic signed [47:0] xpos_q, ypos_q;
  logic        [31:0] head_q;

  logic               ov_q;
  logic signed [47:0] xo_q, yo_q;
  logic        [31:0] ho_q;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [50:0] mul_p;
  logic signed [40:0] opd;
  logic signed [33:0] cos_v, sin_v;

  // helper values
  logic signed [39:0] dr_v;
  logic signed [40:0] sum41;
  logic        [31:0] ang_v, ang_r;
  logic signed [31:0] ang_s;
  logic               big_v;
  logic signed [33:0] xs_v, ys_v, at_v;
  logic        [41:0] dp_v;
  logic        [48:0] psum_v;
  logic               load_out;

  assign in_i.ready        = (state_q == ddo_pkg::StIdle);
  assign out_o.valid       = ov_q;
  assign out_o.x_out       = xo_q;
  assign out_o.y_out       = yo_q;
  assign out_o.heading_out = ho_q;

  assign cos_v = flip_q ? -cx_q : cx_q;
  assign sin_v = flip_q ? -cy_q : cy_q;

  always_comb begin
    opd = (state_q == ddo_pkg::StTurn) ? diff_q : {ds_q[39], ds_q};
    case (dig_q)
      2'd2:    mul_b = {{8{opd[40]}}, opd[40:32]};
      2'd1:    mul_b = {1'b0, opd[31:16]};
      default: mul_b = {1'b0, opd[15:0]};
    endcase
    unique case (state_q)
      ddo_pkg::StMulL: begin
        mul_a = {10'd0, mpt_q};
        mul_b = {lt_q[15], lt_q};
      end
      ddo_pkg::StMulR: begin
        mul_a = {10'd0, mpt_q};
        mul_b = {rt_q[15], rt_q};
      end
      ddo_pkg::StTurn: mul_a = {8'd0, apm_q};
      ddo_pkg::StMulX: mul_a = cos_v;
      ddo_pkg::StMulY: mul_a = sin_v;
      default:         mul_a = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    if (dig_q == 2'd2) begin
      acc_d = {{21{mul_p[50]}}, mul_p};
    end else begin
      acc_d = (acc_q <<< 16) + {{21{mul_p[50]}}, mul_p};
    end
  end

  assign dr_v  = mul_p[39:0];
  assign sum41 = {dl_q[39], dl_q} + {dr_v[39], dr_v};

  // midpoint angle folded into the right half-plane
  assign ang_v = head_q + half_q;
  assign ang_r = {~ang_v[31], ang_v[30:0]};
  assign ang_s = ang_v;
  assign big_v = (ang_s > 32'sh4000_0000) || (ang_s < -32'sh4000_0000);

  assign xs_v = cx_q >>> step_q;
  assign ys_v = cy_q >>> step_q;
  assign at_v = {2'd0, ddo_pkg::atan_lut(step_q)};

  assign dp_v   = acc_d[71:30];
  assign psum_v = (state_q == ddo_pkg::StMulX)
                ? ({xpos_q[47], xpos_q} + {{7{dp_v[41]}}, dp_v})
                : ({ypos_q[47], ypos_q} + {{7{dp_v[41]}}, dp_v});

  assign load_out = (state_q == ddo_pkg::StOut) && (!ov_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ddo_pkg::StIdle:   if (in_i.valid) state_d = ddo_pkg::StMulL;
      ddo_pkg::StMulL:   state_d = ddo_pkg::StMulR;
      ddo_pkg::StMulR:   state_d = ddo_pkg::StTurn;
      ddo_pkg::StTurn:   if (dig_q == 2'd0) state_d = ddo_pkg::StPrep;
      ddo_pkg::StPrep:   state_d = ddo_pkg::StCordic;
      ddo_pkg::StCordic: if (step_q == LastStep) state_d = ddo_pkg::StMulX;
      ddo_pkg::StMulX:   if (dig_q == 2'd0) state_d = ddo_pkg::StMulY;
      ddo_pkg::StMulY:   if (dig_q == 2'd0) state_d = ddo_pkg::StOut;
      ddo_pkg::StOut:    if (load_out) state_d = ddo_pkg::StIdle;
      default:           state_d = ddo_pkg::StIdle;
    endcase
  end

  // control, configuration and pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddo_pkg::StIdle;
      mpt_q   <= ddo_pkg::MmPerTickReset;
      apm_q   <= ddo_pkg::AnglePerMmReset;
      xpos_q  <= '0;
      ypos_q  <= '0;
      head_q  <= '0;
      ov_q    <= 1'b0;
      dig_q   <= 2'd2;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ddo_pkg::CfgMmPerTick:  mpt_q <= cfg_data_i[23:0];
          ddo_pkg::CfgAnglePerMm: apm_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ddo_pkg::StTurn || state_q == ddo_pkg::StMulX ||
          state_q == ddo_pkg::StMulY) begin
        dig_q <= (dig_q == 2'd0) ? 2'd2 : dig_q - 2'd1;
      end
      if (state_q == ddo_pkg::StPrep) begin
        step_q <= '0;
      end else if (state_q == ddo_pkg::StCordic) begin
        step_q <= step_q + 5'd1;
      end
      if (state_q == ddo_pkg::StMulX && dig_q == 2'd0) begin
        xpos_q <= ddo_pkg::sat48(psum_v);
      end
      if (state_q == ddo_pkg::StMulY && dig_q == 2'd0) begin
        ypos_q <= ddo_pkg::sat48(psum_v);
        head_q <= head_q + turn_q;
      end
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      lt_q <= in_i.left_ticks;
      rt_q <= in_i.right_ticks;
    end
    if (state_q == ddo_pkg::StMulL) begin
      dl_q <= mul_p[39:0];
    end
    if (state_q == ddo_pkg::StMulR) begin
      ds_q   <= sum41[40:1];
      diff_q <= {dr_v[39], dr_v} - {dl_q[39], dl_q};
    end
    if (state_q == ddo_pkg::StTurn || state_q == ddo_pkg::StMulX ||
        state_q == ddo_pkg::StMulY) begin
      acc_q <= acc_d;
    end
    if (state_q == ddo_pkg::StTurn && dig_q == 2'd0) begin
      turn_q <= acc_d[47:16];
      half_q <= acc_d[48:17];
    end
    if (state_q == ddo_pkg::StPrep) begin
      cx_q   <= ddo_pkg::CordicKinv;
      cy_q   <= '0;
      cz_q   <= big_v ? {{2{ang_r[31]}}, ang_r} : {{2{ang_v[31]}}, ang_v};
      flip_q <= big_v;
    end else if (state_q == ddo_pkg::StCordic) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - ys_v;
        cy_q <= cy_q + xs_v;
        cz_q <= cz_q - at_v;
      end else begin
        cx_q <= cx_q + ys_v;
        cy_q <= cy_q - xs_v;
        cz_q <= cz_q + at_v;
      end
    end
    if (load_out) begin
      xo_q <= xpos_q;
      yo_q <= ypos_q;
      ho_q <= head_q;
    end
  end

endmodule
`default_nettype wire

// ----- design/ddo_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks of the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
module ddo_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [47:0] out_x_i,
  input wire [47:0] out_y_i,
  input wire [31:0] out_heading_i
);

  // result item held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({out_x_i, out_y_i, out_heading_i}))
    else $error("result item changed while stalled");

  // busy after each accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // a new result comes only as the sequencer returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result item without return to idle");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_x_i      (out_o.x_out),
  .out_y_i      (out_o.y_out),
  .out_heading_i(out_o.heading_out)
);
`default_nettype wire

// ----- tb/diff_drive_odometry_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// diff_drive_odometry_test
// Self-checking bench for the two-wheel odometry block. Wheel tick items go
// in through a queue-fed driver with random valid gaps, pose items come out
// through a monitor with random ready stalls and are checked field by field
// against a bit-exact in-bench pose integrator (scaling, midpoint CORDIC,
// saturating X/Y, wrapping heading). Phases cover default, zero, full-scale,
// over-wide and random register settings and a long straight run into the
// position limits.
// ----------------------------------------------------------------------------
module diff_drive_odometry_test;

  localparam int CordicSteps = 24;

  localparam logic [ddo_pkg::CfgIdxW-1:0] CfgIdxSpareA = 2'd2;
  localparam logic [ddo_pkg::CfgIdxW-1:0] CfgIdxSpareB = 2'd3;

  localparam logic signed [63:0] PosMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] PosMin = -PosMax - 64'sd1;
  localparam logic signed [63:0] QuarterTurn = 64'sd1073741824;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } ticks_t;

  typedef struct packed {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic        [31:0] heading;
  } pose_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [ddo_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [ddo_pkg::CfgDataW-1:0] cfg_data;

  ddo_in_if  in_if ();
  ddo_out_if out_if ();

  diff_drive_odometry #(
    .CORDIC_STEPS(CordicSteps)
  ) u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // arctangent of 2^-i in binary-angle units
  logic [31:0] atan_rom [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // integrator state and register copies
  logic        [23:0] mm_per_tick;
  logic        [25:0] angle_per_mm;
  logic signed [47:0] x_pos;
  logic signed [47:0] y_pos;
  logic        [31:0] heading;

  ticks_t tick_q [$];
  pose_t  pose_q [$];
  ticks_t drv_item;
  pose_t  exp_pose;
  int     src_gap;
  int     snk_gap;
  bit     stall_en;
  int     err_cnt;
  bit     sat_back;
  logic signed [15:0] sat_v;

  function automatic void rotate_unit(input logic [31:0] ang,
                                      output logic signed [63:0] c,
                                      output logic signed [63:0] s);
    logic signed [63:0] z, x, y, xs, ys;
    logic        [31:0] a2;
    logic               flip;
    int                 i;
    z = {{32{ang[31]}}, ang};
    flip = 1'b0;
    if (z > QuarterTurn || z < -QuarterTurn) begin
      a2 = ang + 32'h8000_0000;
      z = {{32{a2[31]}}, a2};
      flip = 1'b1;
    end
    x = ddo_pkg::CordicKinv;
    y = 64'sd0;
    for (i = 0; i < CordicSteps && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - $signed({32'd0, atan_rom[i]});
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + $signed({32'd0, atan_rom[i]});
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // floor(a * c / 2^30)
  function automatic logic signed [63:0] scale_q30(input logic signed [63:0] a,
                                                   input logic signed [63:0] c);
    logic signed [127:0] p;
    logic signed [127:0] q;
    p = a * c;
    q = p >>> 30;
    return q[63:0];
  endfunction

  function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > PosMax) r = PosMax;
    if (v < PosMin) r = PosMin;
    return r[47:0];
  endfunction

  // one odometry update on the bench copy of the pose
  function automatic pose_t dead_reckon(input logic signed [15:0] lt,
                                        input logic signed [15:0] rt);
    logic signed [63:0] dl, dr, ds, c, s;
    logic        [63:0] prod;
    logic        [31:0] turn, half;
    pose_t              p;
    dl = lt * $signed({1'b0, mm_per_tick});
    dr = rt * $signed({1'b0, mm_per_tick});
    ds = (dl + dr) >>> 1;
    prod = (dr - dl) * {38'd0, angle_per_mm};
    turn = prod[47:16];
    half = prod[48:17];
    rotate_unit(heading + half, c, s);
    x_pos = clamp48({{16{x_pos[47]}}, x_pos} + scale_q30(ds, c));
    y_pos = clamp48({{16{y_pos[47]}}, y_pos} + scale_q30(ds, s));
    heading = heading + turn;
    p.x = x_pos;
    p.y = y_pos;
    p.heading = heading;
    return p;
  endfunction

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  function automatic logic signed [15:0] rand_tick();
    logic signed [15:0] v;
    case ($urandom_range(0, 3))
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(0, 400)) - 16'd200;
      2: begin
        case ($urandom_range(0, 4))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2: v = 16'h0001;
          3: v = 16'hFFFF;
          default: v = 16'h0000;
        endcase
      end
      default: v = 16'($urandom_range(0, 8191)) - 16'd4096;
    endcase
    return v;
  endfunction

  task automatic push_ticks(input logic signed [15:0] lt, input logic signed [15:0] rt);
    ticks_t t;
    t.left = lt;
    t.right = rt;
    tick_q.push_back(t);
  endtask

  task automatic queue_random(input int n);
    logic signed [15:0] lt, rt;
    repeat (n) begin
      lt = rand_tick();
      case ($urandom_range(0, 3))
        0: rt = lt;
        1: rt = -lt;
        2: rt = lt + 16'($urandom_range(0, 64)) - 16'd32;
        default: rt = rand_tick();
      endcase
      push_ticks(lt, rt);
    end
  endtask

  task automatic write_reg(input logic [ddo_pkg::CfgIdxW-1:0] idx,
                           input logic [ddo_pkg::CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ddo_pkg::CfgMmPerTick) begin
      mm_per_tick = data[23:0];
    end else if (idx == ddo_pkg::CfgAnglePerMm) begin
      angle_per_mm = data[25:0];
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (tick_q.size() != 0 || in_if.valid || pose_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("diff_drive_odometry_test: FAIL");
    $finish;
  end

  // item driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        pose_q.push_back(dead_reckon(in_if.left_ticks, in_if.right_ticks));
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          drv_item = tick_q.pop_front();
          in_if.valid       <= 1'b1;
          in_if.left_ticks  <= drv_item.left;
          in_if.right_ticks <= drv_item.right;
          if (stall_en && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 3);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // pose monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pose_q.size() == 0) begin
          note_error($sformatf("unexpected pose x=%0d y=%0d heading=%0h",
                               out_if.x_out, out_if.y_out, out_if.heading_out));
        end else begin
          exp_pose = pose_q.pop_front();
          if (out_if.x_out !== exp_pose.x || out_if.y_out !== exp_pose.y ||
              out_if.heading_out !== exp_pose.heading) begin
            note_error($sformatf({"pose mismatch: exp x=%0d y=%0d heading=%0h, ",
                                  "got x=%0d y=%0d heading=%0h"},
                                 exp_pose.x, exp_pose.y, exp_pose.heading,
                                 out_if.x_out, out_if.y_out, out_if.heading_out));
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (stall_en && $urandom_range(0, 4) == 0) snk_gap = $urandom_range(1, 3);
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = ddo_pkg::CfgMmPerTick;
    cfg_data          = '0;
    in_if.valid       = 1'b0;
    in_if.left_ticks  = '0;
    in_if.right_ticks = '0;
    out_if.ready      = 1'b0;
    src_gap           = 0;
    snk_gap           = 0;
    stall_en          = 1'b1;
    err_cnt           = 0;
    mm_per_tick       = ddo_pkg::MmPerTickReset;
    angle_per_mm      = ddo_pkg::AnglePerMmReset;
    x_pos             = '0;
    y_pos             = '0;
    heading           = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, straight runs, spins and half-turn folding at reset values
    push_ticks(16'sd0, 16'sd0);
    push_ticks(16'sd32767, 16'sd32767);
    push_ticks(-16'sd32768, -16'sd32768);
    push_ticks(16'sd32767, -16'sd32768);
    push_ticks(-16'sd32768, 16'sd32767);
    push_ticks(16'sd1, 16'sd1);
    push_ticks(-16'sd1, -16'sd1);
    push_ticks(16'sd1, -16'sd1);
    push_ticks(-16'sd1, 16'sd1);
    push_ticks(16'sd0, 16'sd32767);
    push_ticks(16'sd32767, 16'sd0);
    push_ticks(16'sd0, -16'sd32768);
    push_ticks(16'sd100, -16'sd100);
    push_ticks(-16'sd100, 16'sd100);
    wait_idle();

    // 1 mm per tick, 2^24 per mm: every heading lands exactly on a quarter turn
    write_reg(ddo_pkg::CfgMmPerTick, 26'd65536);
    write_reg(ddo_pkg::CfgAnglePerMm, 26'd16777216);
    push_ticks(16'sd0, 16'sd64);
    push_ticks(16'sd10, 16'sd10);
    push_ticks(-16'sd32, 16'sd32);
    push_ticks(16'sd0, 16'sd64);
    push_ticks(16'sd5, 16'sd5);
    push_ticks(16'sd32, -16'sd32);
    wait_idle();

    write_reg(ddo_pkg::CfgMmPerTick, {2'b00, ddo_pkg::MmPerTickReset});
    write_reg(ddo_pkg::CfgAnglePerMm, ddo_pkg::AnglePerMmReset);
    queue_random(150);
    wait_idle();

    write_reg(ddo_pkg::CfgMmPerTick, 26'hFF_FFFF);
    write_reg(ddo_pkg::CfgAnglePerMm, 26'h3FF_FFFF);
    queue_random(120);
    wait_idle();

    // zero scale, plus writes to unused indexes that must be dropped
    write_reg(ddo_pkg::CfgMmPerTick, 26'd0);
    write_reg(ddo_pkg::CfgAnglePerMm, 26'd0);
    write_reg(CfgIdxSpareA, 26'($urandom));
    write_reg(CfgIdxSpareB, 26'h3FF_FFFF);
    queue_random(50);
    wait_idle();

    // over-wide value for the 24-bit register
    write_reg(ddo_pkg::CfgMmPerTick, {2'b11, 24'($urandom)});
    write_reg(ddo_pkg::CfgAnglePerMm, 26'($urandom));
    queue_random(120);
    wait_idle();

    // long straight run at full scale into the position limit, then back out
    write_reg(ddo_pkg::CfgMmPerTick, 26'h3FF_FFFF);
    write_reg(ddo_pkg::CfgAnglePerMm, 26'd0);
    sat_back = $urandom_range(0, 1);
    repeat (400) begin
      sat_v = 16'sd32767 - 16'($urandom_range(0, 63));
      if (sat_back) sat_v = ~sat_v;
      push_ticks(sat_v, sat_v - 16'($urandom_range(0, 3)));
    end
    repeat (40) begin
      sat_v = 16'sd32767 - 16'($urandom_range(0, 63));
      if (!sat_back) sat_v = ~sat_v;
      push_ticks(sat_v, sat_v);
    end
    wait_idle();

    // last stretch with no idling on either side
    stall_en = 1'b0;
    write_reg(ddo_pkg::CfgMmPerTick, 26'($urandom_range(0, 24'hFF_FFFF)));
    write_reg(ddo_pkg::CfgAnglePerMm, 26'($urandom));
    queue_random(200);
    wait_idle();

    repeat (60) @(posedge clk);
    if (err_cnt == 0) begin
      $display("diff_drive_odometry_test: PASS");
    end else begin
      $display("diff_drive_odometry_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- diff_drive_odometry.f -----
design/ddo_pkg.sv
design/ddo_if.sv
design/diff_drive_odometry.sv
design/ddo_checker.sv
tb/diff_drive_odometry_test.sv
